[src/acm_pkg.sv]
package acm_pkg;

  // Channel count of the port list, and how many of those channels are built.
  localparam int NumCh     = 8;
  localparam int NumInputs = 8;

  localparam int SampleW  = 16;
  localparam int VolW     = 8;
  localparam int PanW     = 8;
  localparam int WeightW  = 8;
  localparam int ProdW    = 24;                  // sample * volume
  localparam int TermW    = 32;                  // product * pan weight
  localparam int SumW     = TermW + 3;           // sum of eight terms
  localparam int AccW     = SumW + 1;            // after blend
  localparam int MasterW  = 16;
  localparam int YW       = AccW + MasterW + 1;  // after master gain
  localparam int FullShift = 42;                 // saturation bound 2^42
  localparam int YoW      = FullShift + 2;       // offset value 0 .. 2^43
  localparam int SplitW   = 21;
  localparam int KW       = 31;
  localparam int AkW      = YoW - SplitW + KW;
  localparam int BkW      = SplitW + KW;
  localparam int CodeW    = 32;
  localparam int OutW     = 16;
  localparam int NarrowW  = 8;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 3;

  localparam logic [WeightW-1:0] WeightFull = WeightW'(128);
  localparam logic [WeightW-1:0] WeightHalf = WeightW'(64);
  localparam int MonoShift = 7;

  localparam logic [KW-1:0] CodeK = 31'h7FFF_FFFF;

  localparam int LaneStages   = 2;
  localparam int MergeStages  = 2;
  localparam int FinishStages = 6;
  localparam int Latency      = LaneStages + MergeStages + FinishStages;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnableMask     = 3'd0,
    RegChannelVolumes = 3'd1,
    RegChannelPans    = 3'd2,
    RegMasterVolume   = 3'd3,
    RegStereoOut      = 3'd4,
    RegWideOutput     = 3'd5,
    RegUnsignedOut    = 3'd6,
    RegSwapLr         = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TermW-1:0] left;
    logic signed [TermW-1:0] right;
    logic signed [TermW-1:0] mono;
  } lane_term_t;

  typedef struct packed {
    logic wide;        // 16-bit codes
    logic offset_bin;  // flip sign bit
    logic zero;        // force code to zero
  } fin_cfg_t;

endpackage

[src/audio_channel_mixdown.sv]
// Channel   Signals                                   Direction  Transfer
// --------  ----------------------------------------  ---------  ------------------------
// frame in  start_i, busy_o, sample_0_i..7_i,         in         start_i && !busy_o
//           end_of_buffer_i
// result    done_o, left_code_o, right_code_o,        out        done_o, one cycle, no stall
//           last_frame_o
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i           in         cfg_we_i
//
// One frame per cycle, sustained. The datapath holds Latency = 10 register stages
// (2 lane stages, 2 merge stages, 6 finish stages); the first of them loads at the frame
// transfer edge, and done_o is high while that frame's result sits in the last of them.
// The pipeline is free running, so busy_o stays low and frames may arrive every cycle.
// The two multipliers per lane and the master/code multipliers of the finish units
// set the stage count.
// Reset (rst_ni low, asynchronous) clears the frame valid pipe and loads register defaults.
// The receiver cannot stall: done_o pulses for one cycle per frame, in frame order.
module audio_channel_mixdown import acm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  input  logic signed [SampleW-1:0] sample_0_i,
  input  logic signed [SampleW-1:0] sample_1_i,
  input  logic signed [SampleW-1:0] sample_2_i,
  input  logic signed [SampleW-1:0] sample_3_i,
  input  logic signed [SampleW-1:0] sample_4_i,
  input  logic signed [SampleW-1:0] sample_5_i,
  input  logic signed [SampleW-1:0] sample_6_i,
  input  logic signed [SampleW-1:0] sample_7_i,
  input  logic                      end_of_buffer_i,
  output logic                      done_o,
  output logic [OutW-1:0]           left_code_o,
  output logic [OutW-1:0]           right_code_o,
  output logic                      last_frame_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [NumCh-1:0]      enable_mask_q;
  logic [NumCh*VolW-1:0] channel_volumes_q;
  logic [NumCh*PanW-1:0] channel_pans_q;
  logic [MasterW-1:0]    master_volume_q;
  logic                  stereo_out_q;
  logic                  wide_output_q;
  logic                  unsigned_out_q;
  logic                  swap_lr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q     <= '0;
      channel_volumes_q <= '0;
      channel_pans_q    <= '0;
      master_volume_q   <= MasterW'(4096);  // unity gain
      stereo_out_q      <= 1'b1;
      wide_output_q     <= 1'b1;
      unsigned_out_q    <= 1'b0;
      swap_lr_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegEnableMask:     enable_mask_q     <= cfg_wdata_i[NumCh-1:0];
        RegChannelVolumes: channel_volumes_q <= cfg_wdata_i[NumCh*VolW-1:0];
        RegChannelPans:    channel_pans_q    <= cfg_wdata_i[NumCh*PanW-1:0];
        RegMasterVolume:   master_volume_q   <= cfg_wdata_i[MasterW-1:0];
        RegStereoOut:      stereo_out_q      <= cfg_wdata_i[0];
        RegWideOutput:     wide_output_q     <= cfg_wdata_i[0];
        RegUnsignedOut:    unsigned_out_q    <= cfg_wdata_i[0];
        RegSwapLr:         swap_lr_q         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame tracking: valid and end-of-buffer ride alongside the datapath
  // ---------------------------------------------------------------------------
  logic               accept;
  logic [Latency-1:0] vld_q, vld_d;
  logic [Latency-1:0] last_q, last_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign vld_d  = {vld_q[Latency-2:0], accept};
  assign last_d = {last_q[Latency-2:0], end_of_buffer_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  // ---------------------------------------------------------------------------
  // Lanes: one per channel, volume then pan split
  // ---------------------------------------------------------------------------
  logic signed [SampleW-1:0] samples [NumCh];
  lane_term_t                terms   [NumCh];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  for (genvar c = 0; c < NumCh; c++) begin : g_lane
    if (c < NumInputs) begin : g_on
      acm_lane u_lane (
        .clk_i    (clk_i),
        .enable_i (enable_mask_q[c]),
        .sample_i (samples[c]),
        .volume_i (channel_volumes_q[c*VolW +: VolW]),
        .pan_i    ($signed(channel_pans_q[c*PanW +: PanW])),
        .term_o   (terms[c])
      );
    end else begin : g_off
      // channel not built: contributes nothing
      assign terms[c] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Merge: sum lanes, blend or mono select, swap
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0] acc_l, acc_r;

  acm_merge u_merge (
    .clk_i    (clk_i),
    .terms_i  (terms),
    .stereo_i (stereo_out_q),
    .swap_i   (swap_lr_q),
    .acc_l_o  (acc_l),
    .acc_r_o  (acc_r)
  );

  // ---------------------------------------------------------------------------
  // Finish: master gain, saturation, code conversion per side
  // User must hold config static with frames in flight (not enforced); it is read directly.
  // ---------------------------------------------------------------------------
  fin_cfg_t cfg_l, cfg_r;

  assign cfg_l = '{wide: wide_output_q, offset_bin: unsigned_out_q, zero: 1'b0};
  assign cfg_r = '{wide: wide_output_q, offset_bin: unsigned_out_q, zero: !stereo_out_q};

  acm_finish u_finish_l (
    .clk_i    (clk_i),
    .cfg_i    (cfg_l),
    .master_i (master_volume_q),
    .acc_i    (acc_l),
    .code_o   (left_code_o)
  );

  acm_finish u_finish_r (
    .clk_i    (clk_i),
    .cfg_i    (cfg_r),
    .master_i (master_volume_q),
    .acc_i    (acc_r),
    .code_o   (right_code_o)
  );

  assign done_o       = vld_q[Latency-1];
  assign last_frame_o = last_q[Latency-1];

`ifndef ASSERT_OFF
  // a result strobe only follows an accepted frame that has passed through every pipeline stage
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without matching frame transfer");

  // mono mode keeps the right code at zero
  a_mono_right_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !stereo_out_q) |-> (right_code_o == '0))
    else $error("right code nonzero in mono mode");

  // narrow mode leaves the upper byte of both codes clear
  a_narrow_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !wide_output_q) |->
      (left_code_o[OutW-1:NarrowW] == '0) && (right_code_o[OutW-1:NarrowW] == '0))
    else $error("upper code byte set in narrow mode");
`endif

endmodule

[src/acm_lane.sv]
module acm_lane import acm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      enable_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [VolW-1:0]           volume_i,
  input  logic signed [PanW-1:0]    pan_i,
  output lane_term_t                term_o
);

  logic signed [SampleW+VolW:0]   prod_full;
  logic signed [ProdW-1:0]        p_d, p_q;
  logic [WeightW-1:0]             pan_mag;
  logic [WeightW-1:0]             lw_d, lw_q, rw_d, rw_q;
  logic signed [ProdW+WeightW:0]  left_full, right_full;
  logic signed [TermW-1:0]        p_ext;
  lane_term_t                     term_d, term_q;

  // stage 1: volume product and pan weights
  always_comb begin
    prod_full = sample_i * $signed({1'b0, volume_i});
    p_d       = enable_i ? prod_full[ProdW-1:0] : '0;
    pan_mag   = WeightW'(~pan_i) + WeightW'(1);
    if (pan_i[PanW-1]) begin
      lw_d = pan_mag;
      rw_d = WeightFull - pan_mag;
    end else if (pan_i != '0) begin
      rw_d = WeightW'(pan_i);
      lw_d = WeightFull - WeightW'(pan_i);
    end else begin
      lw_d = WeightHalf;
      rw_d = WeightHalf;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    lw_q <= lw_d;
    rw_q <= rw_d;
  end

  // stage 2: pan split and mono term
  always_comb begin
    left_full    = p_q * $signed({1'b0, lw_q});
    right_full   = p_q * $signed({1'b0, rw_q});
    p_ext        = TermW'(p_q);
    term_d.left  = left_full[TermW-1:0];
    term_d.right = right_full[TermW-1:0];
    term_d.mono  = p_ext <<< MonoShift;
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign term_o = term_q;

endmodule

[src/acm_merge.sv]
module acm_merge import acm_pkg::*; (
  input  logic                   clk_i,
  input  lane_term_t             terms_i [NumCh],
  input  logic                   stereo_i,
  input  logic                   swap_i,
  output logic signed [AccW-1:0] acc_l_o,
  output logic signed [AccW-1:0] acc_r_o
);

  logic signed [SumW-1:0] sum_l_d, sum_r_d, sum_m_d;
  logic signed [SumW-1:0] sum_l_q, sum_r_q, sum_m_q;
  logic signed [AccW-1:0] l_ext, r_ext, m_ext, lb, rb;
  logic signed [AccW-1:0] acc_l_d, acc_r_d, acc_l_q, acc_r_q;

  // stage A: sum over lanes
  always_comb begin
    sum_l_d = '0;
    sum_r_d = '0;
    sum_m_d = '0;
    for (int c = 0; c < NumCh; c++) begin
      sum_l_d = sum_l_d + SumW'($signed(terms_i[c].left));
      sum_r_d = sum_r_d + SumW'($signed(terms_i[c].right));
      sum_m_d = sum_m_d + SumW'($signed(terms_i[c].mono));
    end
  end

  always_ff @(posedge clk_i) begin
    sum_l_q <= sum_l_d;
    sum_r_q <= sum_r_d;
    sum_m_q <= sum_m_d;
  end

  // stage B: cross-blend, swap, mono select
  always_comb begin
    l_ext = AccW'(sum_l_q);
    r_ext = AccW'(sum_r_q);
    m_ext = AccW'(sum_m_q);
    lb    = (l_ext <<< 1) + r_ext;
    rb    = (r_ext <<< 1) + l_ext;
    if (!stereo_i) begin
      acc_l_d = m_ext <<< 1;
      acc_r_d = '0;
    end else if (swap_i) begin
      acc_l_d = rb;
      acc_r_d = lb;
    end else begin
      acc_l_d = lb;
      acc_r_d = rb;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
  end

  assign acc_l_o = acc_l_q;
  assign acc_r_o = acc_r_q;

endmodule

[src/acm_finish.sv]
module acm_finish import acm_pkg::*; (
  input  logic                   clk_i,
  input  fin_cfg_t               cfg_i,
  input  logic [MasterW-1:0]     master_i,
  input  logic signed [AccW-1:0] acc_i,
  output logic [OutW-1:0]        code_o
);

  localparam logic signed [YW-1:0] FullPos = YW'(64'd1 << FullShift);
  localparam logic signed [YW-1:0] FullNeg = -FullPos;
  localparam logic [BkW:0]         RoundC  = (BkW+1)'(64'd1 << (2 * SplitW - 1));

  logic signed [YW-1:0]    y_q, y_sat, yo_full;
  logic [YoW-1:0]          yo_q;
  logic [AkW-1:0]          ak_q, ak2_q;
  logic [BkW-1:0]          bk_q;
  logic [BkW:0]            bk_rnd;
  logic [CodeW-1:0]        low_q;
  logic [AkW:0]            r_sum;
  logic [CodeW-1:0]        r_q, code;
  logic [OutW-1:0]         code_d, code_q;

  // F1: master gain
  always_ff @(posedge clk_i) begin
    y_q <= acc_i * $signed({1'b0, master_i});
  end

  // F2: saturate to +-2^42 and offset to non-negative
  always_comb begin
    if (y_q > FullPos) begin
      y_sat = FullPos;
    end else if (y_q < FullNeg) begin
      y_sat = FullNeg;
    end else begin
      y_sat = y_q;
    end
    yo_full = y_sat + FullPos;
  end

  always_ff @(posedge clk_i) begin
    yo_q <= yo_full[YoW-1:0];
  end

  // F3: scale both halves by 2^31-1
  always_ff @(posedge clk_i) begin
    ak_q <= yo_q[YoW-1:SplitW] * CodeK;
    bk_q <= yo_q[SplitW-1:0] * CodeK;
  end

  // F4: round low half
  assign bk_rnd = {1'b0, bk_q} + RoundC;

  always_ff @(posedge clk_i) begin
    low_q <= bk_rnd[BkW:SplitW];
    ak2_q <= ak_q;
  end

  // F5: combine halves
  assign r_sum = {1'b0, ak2_q} + (AkW+1)'(low_q);

  always_ff @(posedge clk_i) begin
    r_q <= r_sum[SplitW+CodeW-1:SplitW];
  end

  // F6: recenter, sign flip, width select or zero
  always_comb begin
    code        = r_q - CodeW'(CodeK);
    code[CodeW-1] = code[CodeW-1] ^ cfg_i.offset_bin;
    if (cfg_i.zero) begin
      code_d = '0;
    end else if (cfg_i.wide) begin
      code_d = code[CodeW-1:CodeW-OutW];
    end else begin
      code_d = OutW'(code[CodeW-1:CodeW-NarrowW]);
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule
